// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants for the page frame allocator: sizes, command codes,
// status codes and the register map.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Frame space and free stack capacity
    localparam int unsigned NUM_FRAMES = 65536;
    localparam int unsigned FRAME_W    = 16;
    localparam int unsigned TABLE_SIZE = 65536;
    localparam int unsigned STACK_CAP  = (NUM_FRAMES < 65536) ? NUM_FRAMES : 65536;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned TOTAL_W    = 17;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [2:0]         cmd_t;
    typedef logic [1:0]         status_t;

    // Commands
    localparam cmd_t CMD_ALLOC = 3'd0;
    localparam cmd_t CMD_FREE  = 3'd1;
    localparam cmd_t CMD_INC   = 3'd2;
    localparam cmd_t CMD_DEC   = 3'd3;
    localparam cmd_t CMD_GET   = 3'd4;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Register map (byte addresses)
    localparam int unsigned ADDR_W      = 2;
    localparam logic [1:0]  ADDR_LOWEST = 2'd0;

    localparam count_t COUNT_MAX = 8'hFF;

endpackage

// ----- rtl/page_frame_allocator_refcount.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// LIFO free-frame allocator with an 8-bit reference count per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, cmd, frame) takes one item: allocate,
//   free, increment, decrement or read count. Output channel (out_valid /
//   out_stall) returns one result item per input item: status, granted
//   frame, resulting count and the free-page total.
//   The result is registered in the update step. An item is taken only in
//   the idle state, not while an update is pending. The accept cycle issues
//   the read of the count memory (or the stack top for allocate); the update
//   step updates, writes the count back and pushes a freed frame.
//   Reset: the count memory is swept to zero, one entry per cycle, over all
//   65536 entries; in_stall stays high meanwhile. The register
//   lowest_frame (APB, byte address 0) can be written at any time.
//   Stall: a result waits in the output register while out_stall is high.
//   The next item is still accepted; its update waits until the output
//   register is free, so no result is lost or overwritten.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfa_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [15:0]                    frame,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [15:0]                    granted_frame,
    output logic [7:0]                     ref_count,
    output logic [16:0]                    free_pages
);

    // Sequencer codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam pfa_pkg::frame_t FRAME_LAST = '1;

    // Memories
    pfa_pkg::count_t ref_mem   [pfa_pkg::TABLE_SIZE];
    pfa_pkg::frame_t stack_mem [pfa_pkg::STACK_CAP];

    logic [1:0]       state_reg, state_next;
    pfa_pkg::frame_t  clr_addr_reg;
    pfa_pkg::frame_t  lowest_reg;
    pfa_pkg::total_t  free_total_reg, free_total_next;
    pfa_pkg::cmd_t    cmd_reg;
    pfa_pkg::frame_t  frame_reg;
    pfa_pkg::count_t  ref_rd;
    pfa_pkg::frame_t  stack_rd;

    logic             out_valid_reg;
    pfa_pkg::status_t status_reg;
    pfa_pkg::frame_t  granted_reg;
    pfa_pkg::count_t  count_reg;
    pfa_pkg::total_t  free_pages_reg;

    logic             accept;
    logic             out_load;
    logic             cfg_write;

    // Results of the update step
    pfa_pkg::status_t ex_status;
    pfa_pkg::frame_t  ex_granted;
    pfa_pkg::count_t  ex_count;
    logic             ex_ref_we;
    pfa_pkg::frame_t  ex_ref_addr;
    logic             ex_push;

    logic             ref_we;
    pfa_pkg::frame_t  ref_waddr;
    pfa_pkg::count_t  ref_wdata;
    pfa_pkg::frame_t  stack_raddr;
    logic             in_range;
    logic             above_low;
    logic             stack_full;

    // Handshakes
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign cfg_write = psel && penable && pwrite && (paddr == pfa_pkg::ADDR_LOWEST);

    // APB port
    assign pready = 1'b1;
    assign prdata = (paddr == pfa_pkg::ADDR_LOWEST) ? {16'd0, lowest_reg} : 32'd0;

    // Stack top address for allocate (only used when the stack is not empty)
    assign stack_raddr = free_total_reg[pfa_pkg::FRAME_W-1:0] - 16'd1;

    // Range checks for the update step
    assign in_range   = (32'(frame_reg) < pfa_pkg::NUM_FRAMES);
    assign above_low  = (frame_reg >= lowest_reg);
    assign stack_full = (32'(free_total_reg) >= pfa_pkg::STACK_CAP);

    // Update step: read data from the accept cycle is available here
    always_comb
    begin
        ex_status       = pfa_pkg::ST_OK;
        ex_granted      = '0;
        ex_count        = '0;
        ex_ref_we       = 1'b0;
        ex_ref_addr     = frame_reg;
        ex_push         = 1'b0;
        free_total_next = free_total_reg;
        unique case (cmd_reg)
            pfa_pkg::CMD_ALLOC:
            begin
                if (free_total_reg == '0)
                begin
                    ex_status = pfa_pkg::ST_EMPTY;
                end
                else
                begin
                    free_total_next = free_total_reg - 17'd1;
                    ex_granted      = stack_rd;
                    ex_ref_addr     = stack_rd;
                    ex_ref_we       = 1'b1;
                    ex_count        = 8'd1;
                end
            end
            pfa_pkg::CMD_FREE:
            begin
                if (!above_low || !in_range)
                begin
                    ex_status = pfa_pkg::ST_RANGE;
                end
                else
                begin
                    ex_count  = (ref_rd != '0) ? ref_rd - 8'd1 : '0;
                    ex_ref_we = 1'b1;
                    if (ex_count == '0)
                    begin
                        if (stack_full)
                        begin
                            ex_status = pfa_pkg::ST_FULL;
                        end
                        else
                        begin
                            ex_push         = 1'b1;
                            free_total_next = free_total_reg + 17'd1;
                        end
                    end
                end
            end
            pfa_pkg::CMD_INC, pfa_pkg::CMD_DEC, pfa_pkg::CMD_GET:
            begin
                if (!in_range)
                begin
                    ex_status = pfa_pkg::ST_RANGE;
                end
                else
                begin
                    ex_ref_we = 1'b1;
                    if (cmd_reg == pfa_pkg::CMD_INC && ref_rd != pfa_pkg::COUNT_MAX)
                        ex_count = ref_rd + 8'd1;
                    else if (cmd_reg == pfa_pkg::CMD_DEC && ref_rd != '0)
                        ex_count = ref_rd - 8'd1;
                    else
                        ex_count = ref_rd;
                end
            end
            default:
            begin
                ex_status = pfa_pkg::ST_OK;
            end
        endcase
    end

    // Count memory write port: clearing sweep or update write-back
    always_comb
    begin
        ref_we    = 1'b0;
        ref_waddr = frame_reg;
        ref_wdata = ex_count;
        if (state_reg == S_CLEAR)
        begin
            ref_we    = 1'b1;
            ref_waddr = clr_addr_reg;
            ref_wdata = '0;
        end
        else if (out_load && ex_ref_we)
        begin
            ref_we    = 1'b1;
            ref_waddr = ex_ref_addr;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_addr_reg == FRAME_LAST) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (out_load) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            lowest_reg     <= '0;
            free_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + 16'd1;
            if (cfg_write)
                lowest_reg <= pwdata[15:0];
            if (out_load)
            begin
                free_total_reg <= free_total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            frame_reg <= frame;
        end
        if (out_load)
        begin
            status_reg     <= ex_status;
            granted_reg    <= ex_granted;
            count_reg      <= ex_count;
            free_pages_reg <= free_total_next;
        end
    end

    // Count memory
    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[ref_waddr] <= ref_wdata;
        if (accept)
            ref_rd <= ref_mem[frame];
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (out_load && ex_push)
            stack_mem[free_total_reg[pfa_pkg::FRAME_W-1:0]] <= frame_reg;
        if (accept)
            stack_rd <= stack_mem[stack_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_frame = granted_reg;
    assign ref_count     = count_reg;
    assign free_pages    = free_pages_reg;

    // Assertions
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_total_reg) <= pfa_pkg::STACK_CAP)
        else $error("free total exceeds stack capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter update step");

    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(free_total_reg))
        else $error("free total changed without a result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == pfa_pkg::ST_EMPTY)
            |-> (granted_reg == '0 && count_reg == '0 && free_pages_reg == '0))
        else $error("empty result carries nonzero fields");

endmodule

// ----- verif/tb_page_frame_allocator_refcount.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_refcount
// Self-checking bench for the page frame allocator. A queue of requests
// feeds a clocked driver. Each accepted request runs through a behavioral
// copy of the free stack and the count table, and the predicted answer is
// queued. A clocked monitor compares every answer with the oldest
// prediction. The stimulus covers directed corner cases and randomized
// free/alloc/count sequences under several lowest_frame settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_refcount;

    // Spare command codes, no operation in the block
    localparam pfa_pkg::cmd_t CMD_SPARE_A = 3'd5;
    localparam pfa_pkg::cmd_t CMD_SPARE_B = 3'd6;
    localparam pfa_pkg::cmd_t CMD_SPARE_C = 3'd7;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 350;

    typedef struct packed {
        pfa_pkg::cmd_t   cmd;
        pfa_pkg::frame_t frame;
    } pfa_request_t;

    typedef struct packed {
        pfa_pkg::status_t status;
        pfa_pkg::frame_t  granted;
        pfa_pkg::count_t  count;
        pfa_pkg::total_t  free_pages;
    } pfa_answer_t;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [pfa_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    pfa_pkg::cmd_t    cmd       = pfa_pkg::CMD_ALLOC;
    pfa_pkg::frame_t  frame     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pfa_pkg::status_t status;
    pfa_pkg::frame_t  granted_frame;
    pfa_pkg::count_t  ref_count;
    pfa_pkg::total_t  free_pages;

    // Behavioral copy of the allocator state
    bit [pfa_pkg::COUNT_W-1:0] model_counts [pfa_pkg::TABLE_SIZE];
    bit [pfa_pkg::FRAME_W-1:0] model_stack [pfa_pkg::STACK_CAP];
    int               model_depth = 0;
    pfa_pkg::frame_t  low_frame   = '0;

    pfa_request_t request_q [$];
    pfa_answer_t  answer_q [$];
    int           n_requests_posted = 0;
    int           n_requests_taken  = 0;
    int           n_errors          = 0;
    int           send_idle_pct     = 0;
    int           stall_pct         = 0;
    int           cycle_count       = 0;
    logic         in_taken          = 1'b0;

    page_frame_allocator_refcount dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_frame (granted_frame),
        .ref_count     (ref_count),
        .free_pages    (free_pages)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the model and return the answer it produces
    function automatic pfa_answer_t allocator_step(pfa_pkg::cmd_t c, pfa_pkg::frame_t f);
        pfa_answer_t r;
        r = '0;
        r.status = pfa_pkg::ST_OK;
        case (c)
            pfa_pkg::CMD_ALLOC:
            begin
                if (model_depth == 0)
                    r.status = pfa_pkg::ST_EMPTY;
                else
                begin
                    model_depth--;
                    r.granted = model_stack[model_depth];
                    model_counts[r.granted] = 1;
                    r.count = 1;
                end
            end
            pfa_pkg::CMD_FREE:
            begin
                if (f < low_frame || 32'(f) >= pfa_pkg::NUM_FRAMES)
                    r.status = pfa_pkg::ST_RANGE;
                else
                begin
                    if (model_counts[f] != 0)
                        model_counts[f]--;
                    // last reference gone: back onto the stack
                    if (model_counts[f] == 0)
                    begin
                        if (model_depth >= pfa_pkg::STACK_CAP)
                            r.status = pfa_pkg::ST_FULL;
                        else
                        begin
                            model_stack[model_depth] = f;
                            model_depth++;
                        end
                    end
                    r.count = model_counts[f];
                end
            end
            pfa_pkg::CMD_INC, pfa_pkg::CMD_DEC, pfa_pkg::CMD_GET:
            begin
                if (32'(f) >= pfa_pkg::NUM_FRAMES)
                    r.status = pfa_pkg::ST_RANGE;
                else
                begin
                    if (c == pfa_pkg::CMD_INC && model_counts[f] != pfa_pkg::COUNT_MAX)
                        model_counts[f]++;
                    else if (c == pfa_pkg::CMD_DEC && model_counts[f] != 0)
                        model_counts[f]--;
                    r.count = model_counts[f];
                end
            end
            default:
                ;
        endcase
        r.free_pages = pfa_pkg::total_t'(model_depth);
        return r;
    endfunction

    task automatic compare_answer(pfa_answer_t want, pfa_answer_t got);
        if (got.status !== want.status)
        begin
            n_errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        end
        if (got.granted !== want.granted)
        begin
            n_errors++;
            $display("%0t: granted_frame expected %0h, got %0h", $time,
                     want.granted, got.granted);
        end
        if (got.count !== want.count)
        begin
            n_errors++;
            $display("%0t: ref_count expected %0d, got %0d", $time, want.count, got.count);
        end
        if (got.free_pages !== want.free_pages)
        begin
            n_errors++;
            $display("%0t: free_pages expected %0d, got %0d", $time,
                     want.free_pages, got.free_pages);
        end
    endtask

    // Monitor: check answers, then predict for the request taken this edge
    always @(posedge clk)
    begin
        pfa_answer_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.status     = status;
                got.granted    = granted_frame;
                got.count      = ref_count;
                got.free_pages = free_pages;
                if (answer_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: answer with none expected, got %0h", $time, got);
                end
                else
                    compare_answer(answer_q.pop_front(), got);
            end
            if (in_valid && !in_stall)
            begin
                answer_q.push_back(allocator_step(cmd, frame));
                n_requests_taken++;
            end
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // Driver: next request once the current one is taken, random idle and stall
    always @(negedge clk)
    begin
        pfa_request_t req;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = request_q.pop_front();
                in_valid <= 1'b1;
                cmd      <= req.cmd;
                frame    <= req.frame;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("page_frame_allocator_refcount test failed");
            $finish;
        end
    end

    task automatic add_item(pfa_pkg::cmd_t c, pfa_pkg::frame_t f);
        pfa_request_t req;
        req.cmd   = c;
        req.frame = f;
        request_q.push_back(req);
        n_requests_posted++;
    endtask

    // Wait until every request is taken and every answer has come back
    task automatic drain();
        while (n_requests_taken != n_requests_posted || answer_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_lowest_frame(pfa_pkg::frame_t v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pfa_pkg::ADDR_LOWEST;
        pwdata  <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        low_frame = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic over a small pool of frames: the extremes, lowest_frame and its neighbours, and random frames
    task automatic random_phase(int n_items, bit with_burst);
        pfa_pkg::frame_t pool [12];
        pfa_pkg::frame_t f;
        int     k;
        int     kind;
        int     done;
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = low_frame;
        pool[3] = low_frame - 1'b1;
        pool[4] = low_frame + 1'b1;
        for (k = 5; k < 12; k++)
            pool[k] = pfa_pkg::frame_t'($urandom);
        done = 0;
        // saturate one count and step it down three times
        if (with_burst)
        begin
            f = pool[$urandom_range(11)];
            for (k = 0; k < 258; k++)
                add_item(pfa_pkg::CMD_INC, f);
            for (k = 0; k < 3; k++)
                add_item(pfa_pkg::CMD_DEC, f);
            add_item(pfa_pkg::CMD_GET, f);
        end
        while (done < n_items)
        begin
            f    = pool[$urandom_range(11)];
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // free, reallocate, share, release
                add_item(pfa_pkg::CMD_FREE, f);
                add_item(pfa_pkg::CMD_ALLOC, pfa_pkg::frame_t'($urandom));
                add_item(pfa_pkg::CMD_INC, f);
                add_item(pfa_pkg::CMD_GET, f);
                add_item(pfa_pkg::CMD_DEC, f);
                add_item(pfa_pkg::CMD_FREE, f);
                done += 6;
            end
            else if (kind < 90)
            begin
                add_item(pfa_pkg::cmd_t'($urandom_range(pfa_pkg::CMD_GET)), f);
                done++;
            end
            else
            begin
                add_item(pfa_pkg::cmd_t'($urandom_range(CMD_SPARE_C)),
                         pfa_pkg::frame_t'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_lowest_frame('0);

        // Directed: empty stack, extremes, duplicate push, saturation at zero
        add_item(pfa_pkg::CMD_ALLOC, '0);
        add_item(pfa_pkg::CMD_GET, '0);
        add_item(pfa_pkg::CMD_GET, '1);
        add_item(pfa_pkg::CMD_FREE, '0);
        add_item(pfa_pkg::CMD_FREE, '1);
        add_item(pfa_pkg::CMD_FREE, '1);
        add_item(pfa_pkg::CMD_INC, '1);
        add_item(pfa_pkg::CMD_DEC, '1);
        add_item(pfa_pkg::CMD_DEC, '1);
        add_item(pfa_pkg::CMD_ALLOC, '1);
        add_item(pfa_pkg::CMD_FREE, '1);
        add_item(CMD_SPARE_A, '1);
        add_item(CMD_SPARE_B, '0);
        add_item(CMD_SPARE_C, 16'h5555);
        add_item(pfa_pkg::CMD_ALLOC, 16'hAAAA);
        add_item(pfa_pkg::CMD_ALLOC, '0);
        add_item(pfa_pkg::CMD_ALLOC, '1);
        add_item(pfa_pkg::CMD_ALLOC, '0);
        drain();

        // Directed: range check against lowest_frame
        set_lowest_frame(16'h8000);
        add_item(pfa_pkg::CMD_FREE, 16'h7FFF);
        add_item(pfa_pkg::CMD_FREE, 16'h8000);
        add_item(pfa_pkg::CMD_INC, 16'h7FFF);
        add_item(pfa_pkg::CMD_ALLOC, 16'hAAAA);
        drain();

        // Random phases with different limits and idle patterns
        set_lowest_frame('0);
        random_phase(PHASE_ITEMS, 1'b1);
        drain();

        set_lowest_frame(pfa_pkg::frame_t'($urandom));
        send_idle_pct = 59;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        set_lowest_frame('1);
        send_idle_pct = 0;
        stall_pct     = 59;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        set_lowest_frame(pfa_pkg::frame_t'($urandom_range(64)));
        send_idle_pct = 18;
        stall_pct     = 18;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("page_frame_allocator_refcount test passed");
        else
            $display("page_frame_allocator_refcount test failed");
        $finish;
    end

endmodule
